// File: rtl/dual_motor_command_controller_unit_macros.svh
// Assertion macros for the dual motor command controller checker.
`ifndef DUAL_MOTOR_COMMAND_CONTROLLER_UNIT_MACROS_SVH
`define DUAL_MOTOR_COMMAND_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define DMCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dmcc check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define DMCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dmcc check failed");

`endif

// File: rtl/dmcc_pkg.sv
// Types, codes and constants shared by the dual motor command controller.
`timescale 1ns / 1ps
`default_nettype none

package dmcc_pkg;

    typedef enum logic [4:0] {
        OP_TICK      = 5'd0,
        OP_STOP      = 5'd1,
        OP_FWD       = 5'd2,
        OP_BACK      = 5'd3,
        OP_LEFT      = 5'd4,
        OP_RIGHT     = 5'd5,
        OP_UTURN     = 5'd6,
        OP_UP        = 5'd7,
        OP_DOWN      = 5'd8,
        OP_CAL_START = 5'd9,
        OP_CAL_END   = 5'd10,
        OP_SEL_L     = 5'd11,
        OP_SEL_R     = 5'd12,
        OP_KEEP_F    = 5'd13,
        OP_KEEP_B    = 5'd14,
        OP_KEEP_L    = 5'd15,
        OP_KEEP_R    = 5'd16,
        OP_ROTATE    = 5'd17
    } op_e;

    typedef enum logic [2:0] {
        MOT_NONE   = 3'd0,
        MOT_FWD    = 3'd1,
        MOT_BACK   = 3'd2,
        MOT_TURN_L = 3'd3,
        MOT_TURN_R = 3'd4,
        MOT_UTURN  = 3'd5
    } motion_e;

    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2
    } trim_sel_e;

    typedef enum logic [2:0] {
        CFG_MOVE_TIMEOUT = 3'd0,
        CFG_TURN_TIME    = 3'd1,
        CFG_TURN_DUTY    = 3'd2,
        CFG_RIGHT_RATIO  = 3'd3,
        CFG_SPEED_STEP   = 3'd4
    } cfg_idx_e;

    // direction lines: bit0 left fwd, bit1 left rev, bit2 right fwd, bit3 right rev
    localparam logic [3:0] LINES_STOP  = 4'h0;
    localparam logic [3:0] LINES_FWD   = 4'h5;
    localparam logic [3:0] LINES_BACK  = 4'hA;
    localparam logic [3:0] LINES_LEFT  = 4'h6;
    localparam logic [3:0] LINES_RIGHT = 4'h9;

    localparam logic [7:0] SPEED_MAX     = 8'd250;
    localparam logic [7:0] SPEED_MIN     = 8'd125;
    localparam logic [7:0] SPEED_DEFAULT = 8'd245;
    localparam logic [7:0] TRIM_STEP     = 8'd5;
    localparam logic [7:0] DUTY_FULL     = 8'd255;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    typedef struct packed {
        logic [4:0] operation;
        logic       rotate_pick_left;
    } in_word_t;

    typedef struct packed {
        logic       left_fwd_line;
        logic       left_rev_line;
        logic       right_fwd_line;
        logic       right_rev_line;
        logic [7:0] left_duty_out;
        logic [7:0] right_duty_out;
        logic       in_calibration;
        logic       save_pulse;
        logic [7:0] saved_left_trim;
        logic [7:0] saved_right_trim;
    } out_word_t;

    typedef struct packed {
        logic [15:0] move_timeout_ms;
        logic [15:0] turn_time_ms;
        logic [7:0]  turn_duty;
        logic [8:0]  right_ratio_q8;
        logic [5:0]  speed_step;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  dir_lines;
        logic [7:0]  left_duty;
        logic [7:0]  right_duty;
        logic [7:0]  left_speed;
        logic [7:0]  right_speed;
        logic [7:0]  left_trim;
        logic [7:0]  right_trim;
        logic        calibrating;
        trim_sel_e   trim_sel;
        motion_e     motion;
        logic [15:0] elapsed_ms;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        move_timeout_ms: 16'd5000,
        turn_time_ms:    16'd2000,
        turn_duty:       8'd127,
        right_ratio_q8:  9'd256,
        speed_step:      6'd12
    };

    localparam state_t STATE_RESET = '{
        dir_lines:   LINES_STOP,
        left_duty:   8'd0,
        right_duty:  8'd0,
        left_speed:  SPEED_DEFAULT,
        right_speed: SPEED_DEFAULT,
        left_trim:   SPEED_DEFAULT,
        right_trim:  SPEED_DEFAULT,
        calibrating: 1'b0,
        trim_sel:    SEL_NONE,
        motion:      MOT_NONE,
        elapsed_ms:  16'd0
    };

endpackage

`default_nettype wire

// File: rtl/dual_motor_command_controller_unit.sv
// Dual motor command controller: top level with state, config and result registers.
// Takes one word per clock on s_ and returns one result word per input word on m_,
// registered, in the cycle after acceptance; s_ready stays high while the result
// register is empty or being drained, so back-to-back words run at one per cycle.
// That rate is set by the single combinational update (one 9x8 multiply and a few
// clamps) between the controller state and the result register. Configuration
// writes take effect at the next edge and should only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_command_controller_unit
    import dmcc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    state_t    state_reg;
    state_t    state_next;
    cfg_t      cfg_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t m_data_next;
    logic      accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    dmcc_step u_step (
        .st       (state_reg),
        .cfg      (cfg_reg),
        .in_word  (s_data),
        .st_next  (state_next),
        .out_word (m_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            cfg_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_e'(cfg_addr))
                    CFG_MOVE_TIMEOUT: cfg_reg.move_timeout_ms <= cfg_wdata;
                    CFG_TURN_TIME:    cfg_reg.turn_time_ms    <= cfg_wdata;
                    CFG_TURN_DUTY:    cfg_reg.turn_duty       <= cfg_wdata[7:0];
                    CFG_RIGHT_RATIO:  cfg_reg.right_ratio_q8  <= cfg_wdata[8:0];
                    CFG_SPEED_STEP:   cfg_reg.speed_step      <= cfg_wdata[5:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                state_reg <= state_next;
            end
            m_valid_reg <= accept || (m_valid_reg && !m_ready);
        end
    end

    // result word, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/dmcc_step.sv
// Next-state and result logic for one word of the motor command controller.
`timescale 1ns / 1ps
`default_nettype none

module dmcc_step
    import dmcc_pkg::*;
(
    input  state_t    st,
    input  cfg_t      cfg,
    input  in_word_t  in_word,
    output state_t    st_next,
    output out_word_t out_word
);

    function automatic logic [7:0] trim_up(input logic [7:0] t);
        logic [8:0] s;
        s = {1'b0, t} + {1'b0, TRIM_STEP};
        return (s > {1'b0, SPEED_MAX}) ? SPEED_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] trim_dn(input logic [7:0] t);
        logic [8:0] floor_v;
        floor_v = {1'b0, SPEED_MIN} + {1'b0, TRIM_STEP};
        return ({1'b0, t} >= floor_v) ? (t - TRIM_STEP) : SPEED_MIN;
    endfunction

    op_e         op;
    logic        cmd;
    logic        save;
    logic        is_up;
    logic [8:0]  up_sum;
    logic [8:0]  dn_floor;
    logic [7:0]  up_left;
    logic [7:0]  dn_left;
    logic [7:0]  new_left;
    logic [16:0] prod;
    logic [8:0]  ratio_r;
    logic [7:0]  up_right;
    logic [7:0]  dn_right;
    logic [7:0]  new_right;
    logic [15:0] elapsed_inc;
    logic [15:0] limit;
    state_t      nx;

    assign op    = op_e'(in_word.operation);
    assign cmd   = (in_word.operation != OP_TICK) && (in_word.operation <= OP_ROTATE);
    assign is_up = (op == OP_UP);

    // speed step on the left side, right side derived through the Q1.8 ratio
    always_comb begin
        up_sum   = {1'b0, st.left_speed} + {3'b0, cfg.speed_step};
        up_left  = (up_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : up_sum[7:0];
        dn_floor = {1'b0, SPEED_MIN} + {3'b0, cfg.speed_step};
        dn_left  = ({1'b0, st.left_speed} >= dn_floor) ?
                   (st.left_speed - {2'b0, cfg.speed_step}) : SPEED_MIN;
        new_left = is_up ? up_left : dn_left;
        prod     = {8'b0, cfg.right_ratio_q8} * {9'b0, new_left};
        ratio_r  = prod[16:8];
        up_right = (ratio_r > {1'b0, SPEED_MAX}) ? SPEED_MAX : ratio_r[7:0];
        if (ratio_r < {1'b0, SPEED_MIN}) begin
            dn_right = SPEED_MIN;
        end else if (ratio_r > {1'b0, DUTY_FULL}) begin
            dn_right = DUTY_FULL;
        end else begin
            dn_right = ratio_r[7:0];
        end
        new_right = is_up ? up_right : dn_right;
    end

    always_comb begin
        elapsed_inc = (st.elapsed_ms == ELAPSED_MAX) ? st.elapsed_ms : st.elapsed_ms + 16'd1;
        limit = (st.motion == MOT_TURN_L || st.motion == MOT_TURN_R) ?
                cfg.turn_time_ms : cfg.move_timeout_ms;
    end

    always_comb begin
        nx   = st;
        save = 1'b0;
        unique case (op)
            OP_TICK: begin
                nx.elapsed_ms = elapsed_inc;
                if (st.motion != MOT_NONE && elapsed_inc > limit) begin
                    nx.dir_lines  = LINES_STOP;
                    nx.left_duty  = 8'd0;
                    nx.right_duty = 8'd0;
                    nx.motion     = MOT_NONE;
                end
            end
            OP_STOP: begin
                nx.motion     = MOT_NONE;
                nx.dir_lines  = LINES_STOP;
                nx.left_duty  = 8'd0;
                nx.right_duty = 8'd0;
            end
            OP_FWD, OP_BACK, OP_KEEP_F, OP_KEEP_B: begin
                nx.dir_lines  = (op == OP_FWD || op == OP_KEEP_F) ? LINES_FWD : LINES_BACK;
                nx.left_duty  = st.left_speed;
                nx.right_duty = st.right_speed;
                if (op == OP_FWD) begin
                    nx.motion = MOT_FWD;
                end else if (op == OP_BACK) begin
                    nx.motion = MOT_BACK;
                end else begin
                    nx.motion = MOT_NONE;
                end
            end
            OP_LEFT: begin
                nx.dir_lines  = LINES_LEFT;
                nx.left_duty  = cfg.turn_duty;
                nx.right_duty = cfg.turn_duty;
                nx.motion     = MOT_TURN_L;
            end
            OP_RIGHT: begin
                nx.dir_lines  = LINES_RIGHT;
                nx.left_duty  = cfg.turn_duty;
                nx.right_duty = cfg.turn_duty;
                nx.motion     = MOT_TURN_R;
            end
            OP_UTURN: begin
                nx.motion = MOT_UTURN;
            end
            OP_UP, OP_DOWN: begin
                if (st.calibrating) begin
                    if (is_up) begin
                        nx.motion = MOT_NONE;
                    end
                    if (st.trim_sel == SEL_LEFT) begin
                        nx.left_trim = is_up ? trim_up(st.left_trim) : trim_dn(st.left_trim);
                        nx.left_duty = nx.left_trim;
                    end else if (st.trim_sel == SEL_RIGHT) begin
                        nx.right_trim = is_up ? trim_up(st.right_trim) : trim_dn(st.right_trim);
                        nx.right_duty = nx.right_trim;
                    end
                end else begin
                    nx.left_speed  = new_left;
                    nx.right_speed = new_right;
                    if (st.motion == MOT_FWD) begin
                        nx.dir_lines = LINES_FWD;
                    end else if (st.motion == MOT_BACK) begin
                        nx.dir_lines = LINES_BACK;
                    end
                    nx.left_duty  = new_left;
                    nx.right_duty = new_right;
                end
            end
            OP_CAL_START: begin
                nx.calibrating = 1'b1;
            end
            OP_CAL_END: begin
                if (st.calibrating) begin
                    nx.calibrating = 1'b0;
                    save           = 1'b1;
                    nx.left_speed  = st.left_trim;
                    nx.right_speed = st.right_trim;
                    nx.trim_sel    = SEL_NONE;
                end
            end
            OP_SEL_L: begin
                nx.trim_sel = SEL_LEFT;
            end
            OP_SEL_R: begin
                nx.trim_sel = SEL_RIGHT;
            end
            OP_KEEP_L: begin
                nx.motion     = MOT_NONE;
                nx.dir_lines  = LINES_FWD;
                nx.left_duty  = cfg.turn_duty;
                nx.right_duty = st.right_speed;
            end
            OP_KEEP_R: begin
                nx.motion     = MOT_NONE;
                nx.dir_lines  = LINES_FWD;
                nx.left_duty  = st.left_speed;
                nx.right_duty = cfg.turn_duty;
            end
            OP_ROTATE: begin
                nx.motion     = MOT_NONE;
                nx.dir_lines  = in_word.rotate_pick_left ? LINES_LEFT : LINES_RIGHT;
                nx.left_duty  = cfg.turn_duty;
                nx.right_duty = cfg.turn_duty;
            end
            default: begin
                // unused codes leave everything as it was
            end
        endcase
        if (cmd) begin
            nx.elapsed_ms = 16'd0;
        end
    end

    assign st_next = nx;

    assign out_word = '{
        left_fwd_line:    nx.dir_lines[0],
        left_rev_line:    nx.dir_lines[1],
        right_fwd_line:   nx.dir_lines[2],
        right_rev_line:   nx.dir_lines[3],
        left_duty_out:    nx.left_duty,
        right_duty_out:   nx.right_duty,
        in_calibration:   nx.calibrating,
        save_pulse:       save,
        saved_left_trim:  nx.left_trim,
        saved_right_trim: nx.right_trim
    };

endmodule

`default_nettype wire

// File: rtl/dmcc_checker.sv
// Port-level checker for the dual motor command controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_motor_command_controller_unit_macros.svh"

module dmcc_checker
    import dmcc_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    `DMCC_ASSERT_NEXT(a_result_follows, s_valid && s_ready, m_valid)
    `DMCC_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))
    `DMCC_ASSERT_NOW(a_save_ends_cal, m_valid && m_data.save_pulse, !m_data.in_calibration)
    `DMCC_ASSERT_NOW(a_no_shoot_through, m_valid,
        !(m_data.left_fwd_line && m_data.left_rev_line) &&
        !(m_data.right_fwd_line && m_data.right_rev_line))

endmodule

bind dual_motor_command_controller_unit dmcc_checker u_dmcc_checker (.*);

`default_nettype wire
